// ===== hw/rtl/arar_pkg.sv =====
// ----------------------------------------------------------------------------
// arar_pkg
// Shared types and opcode constants for the adrp/add/adr address resolver.
// ----------------------------------------------------------------------------
package arar_pkg;

   // opcode masks and match values
   localparam logic [31:0] OP_ADR_MASK   = 32'h9F00_0000;
   localparam logic [31:0] OP_ADRP       = 32'h9000_0000;
   localparam logic [31:0] OP_ADR        = 32'h1000_0000;
   localparam logic [31:0] OP_ADD_MASK   = 32'hFF00_0000;
   localparam logic [31:0] OP_ADD64_IMM  = 32'h9100_0000;
   localparam logic [31:0] ADD_SHIFT_BIT = 32'h0040_0000;
   localparam logic [31:0] IMMHI_MASK    = 32'h001F_FFFC;
   localparam logic [63:0] IMM12_MASK    = 64'h0000_0000_0000_0FFF;

   // register map
   localparam logic REG_TARGET = 1'b0;

   // per-window tracking state
   typedef struct packed {
      logic        page_valid;
      logic [63:0] page_base;
      logic        scan_done;
   } scan_state_type;

   // one result beat from the resolve step
   typedef struct packed {
      logic        emit;
      logic        found;
      logic [63:0] addr;
   } step_result_type;

endpackage

// ===== hw/rtl/arar_csr.sv =====
// ----------------------------------------------------------------------------
// arar_csr
// APB-style configuration register holding the target register number.
// ----------------------------------------------------------------------------
module arar_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [4:0]  target_reg
);

   logic [4:0] target_ff;
   logic [4:0] target_in;
   logic       wr_target;

   // write strobe for the target register
   assign wr_target = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr[2] == arar_pkg::REG_TARGET);

   always_comb begin
      target_in = target_ff;
      if (wr_target) begin
         target_in = csr_pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 5'd0;
      end else begin
         target_ff <= target_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == arar_pkg::REG_TARGET) begin
         csr_prdata = {27'd0, target_ff};
      end
   end

   assign csr_pready = 1'b1;
   assign target_reg = target_ff;

endmodule

// ===== hw/rtl/arar_step.sv =====
// ----------------------------------------------------------------------------
// arar_step
// Decodes one instruction word and computes the next window state and the
// result beat it causes, if any.
// ----------------------------------------------------------------------------
module arar_step (
   input  logic                     [31:0] insn_word,
   input  logic                     [63:0] insn_addr,
   input  logic                            last_word,
   input  logic                     [4:0]  target_reg,
   input  arar_pkg::scan_state_type        cur_state,
   output arar_pkg::scan_state_type        next_state,
   output arar_pkg::step_result_type       result
);

   logic [20:0] imm21;
   logic [63:0] imm_sext;
   logic [63:0] add_imm;
   logic        rd_match;
   logic        is_add;
   logic        is_adrp;
   logic        is_adr;
   logic        hit;
   logic [63:0] hit_addr;
   logic [31:0] immhi;

   // signed 21-bit adr/adrp immediate
   assign immhi    = (insn_word >> 3) & arar_pkg::IMMHI_MASK;
   assign imm21    = {immhi[20:2], insn_word[30:29]};
   assign imm_sext = {{43{imm21[20]}}, imm21};

   // add immediate, optionally shifted by 12
   always_comb begin
      add_imm = {52'd0, insn_word[21:10]};
      if ((insn_word & arar_pkg::ADD_SHIFT_BIT) != 32'd0) begin
         add_imm = {40'd0, insn_word[21:10], 12'd0};
      end
   end

   // opcode decode
   assign rd_match = (insn_word[4:0] == target_reg);
   assign is_add   = cur_state.page_valid
                     && ((insn_word & arar_pkg::OP_ADD_MASK) == arar_pkg::OP_ADD64_IMM)
                     && (insn_word[9:5] == target_reg);
   assign is_adrp  = ((insn_word & arar_pkg::OP_ADR_MASK) == arar_pkg::OP_ADRP);
   assign is_adr   = ((insn_word & arar_pkg::OP_ADR_MASK) == arar_pkg::OP_ADR);

   // state update and resolution
   always_comb begin
      next_state = cur_state;
      hit        = 1'b0;
      hit_addr   = 64'd0;
      if (!cur_state.scan_done && rd_match) begin
         if (is_add) begin
            hit      = 1'b1;
            hit_addr = cur_state.page_base + add_imm;
         end else if (is_adrp) begin
            next_state.page_base  = (insn_addr & ~arar_pkg::IMM12_MASK)
                                    + {imm_sext[51:0], 12'd0};
            next_state.page_valid = 1'b1;
         end else if (is_adr) begin
            hit      = 1'b1;
            hit_addr = insn_addr + imm_sext;
         end else begin
            next_state.page_valid = 1'b0;
         end
         if (hit) begin
            next_state.scan_done = 1'b1;
         end
      end
      if (last_word) begin
         next_state = '0;
      end
   end

   // a hit is reported; otherwise the window end reports not found
   always_comb begin
      result.emit  = hit || (last_word && !cur_state.scan_done);
      result.found = hit;
      result.addr  = hit_addr;
   end

endmodule

// ===== hw/rtl/arm64_adrp_add_resolver.sv =====
// ----------------------------------------------------------------------------
// arm64_adrp_add_resolver
// Scans arm64 instruction words and resolves the address loaded into a chosen
// register through adrp+add or adr.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports                                    | beat
//   req     | in        | insn_word, insn_addr, last_word          | one word
//   rsp     | out       | resolved_addr, found                     | one result
//   csr     | in/out    | psel/penable/pwrite/paddr/pwdata/prdata  | target_reg
//
// One word per cycle sustained while rsp does not stall; a word's result
// is registered as the word leaves the input register. The input register,
// the single-pass decode and add, and the result register form the whole path.
// Synchronous active-high reset clears the window state and target_reg.
// A result held by a stall on rsp freezes the input register, so req stalls
// on the next word whether or not that word produces a result.
//
module arm64_adrp_add_resolver (
   input  logic        clock,
   input  logic        reset,
   // instruction stream
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_insn_word,
   input  logic [63:0] req_insn_addr,
   input  logic        req_last_word,
   // result stream
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_resolved_addr,
   output logic        rsp_found,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [4:0]  target_reg;

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_word_ff, s1_word_in;
   logic [63:0] s1_addr_ff, s1_addr_in;
   logic        s1_last_ff, s1_last_in;

   arar_pkg::scan_state_type  state_ff, state_in, step_state;
   arar_pkg::step_result_type step_res;

   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_addr_ff, out_addr_in;
   logic        out_found_ff, out_found_in;

   logic        advance;
   logic        req_take;

   arar_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .target_reg  (target_reg)
   );

   arar_step u_step (
      .insn_word  (s1_word_ff),
      .insn_addr  (s1_addr_ff),
      .last_word  (s1_last_ff),
      .target_reg (target_reg),
      .cur_state  (state_ff),
      .next_state (step_state),
      .result     (step_res)
   );

   // pipeline moves when the result register is free or being taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_word_in  = s1_word_ff;
      s1_addr_in  = s1_addr_ff;
      s1_last_in  = s1_last_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
      end
      if (req_take) begin
         s1_word_in = req_insn_word;
         s1_addr_in = req_insn_addr;
         s1_last_in = req_last_word;
      end
   end

   // window state follows each word as it leaves the input register
   always_comb begin
      state_in = state_ff;
      if (s1_valid_ff && advance) begin
         state_in = step_state;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_found_in = out_found_ff;
      if (advance) begin
         out_valid_in = s1_valid_ff && step_res.emit;
         out_addr_in  = step_res.addr;
         out_found_in = step_res.found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff   <= s1_word_in;
      s1_addr_ff   <= s1_addr_in;
      s1_last_ff   <= s1_last_in;
      out_addr_ff  <= out_addr_in;
      out_found_ff <= out_found_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_resolved_addr = out_addr_ff;
   assign rsp_found         = out_found_ff;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the adrp/add/adr address resolver. Instruction
// windows are pushed through the req channel while an in-bench tracker of the
// window state predicts each result beat; rsp beats are compared against the
// oldest prediction. Covers directed corner cases, biased random windows
// under three sender/receiver idle mixes and several target registers, and
// a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         PHASE_WORDS   = 200;
   localparam logic [2:0] TARGET_ADDR   = {arar_pkg::REG_TARGET, 2'b00};

   // dut signals
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_insn_word = '0;
   logic [63:0] req_insn_addr = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_resolved_addr;
   logic        rsp_found;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   arm64_adrp_add_resolver u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_insn_word     (req_insn_word),
      .req_insn_addr     (req_insn_addr),
      .req_last_word     (req_last_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_resolved_addr (rsp_resolved_addr),
      .rsp_found         (rsp_found),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // expected result beats, oldest first
   typedef struct {
      logic [63:0] addr;
      logic        found;
   } resolution_type;

   resolution_type pending_resolutions[$];
   resolution_type oldest;

   // tracked window state and configuration
   logic [4:0]  cur_target = '0;
   logic        page_held = 1'b0;
   logic [63:0] held_page = '0;
   logic        window_resolved = 1'b0;

   int errors = 0;
   int words_sent = 0;
   int words_used = 0;
   int found_checked = 0;
   int missing_checked = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   bit hold_request = 1'b0;

   always #5ns clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic log_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   // append one expected beat at the tail of the queue
   function automatic void expect_result(input logic [63:0] addr, input logic found);
      resolution_type r;
      r.addr  = addr;
      r.found = found;
      pending_resolutions.insert(pending_resolutions.size(), r);
   endfunction

   // advance the tracked window by one accepted word; returns 1 unless ignored
   function automatic bit track_word(input logic [31:0] w, input logic [63:0] a,
                                     input logic last);
      logic [63:0] off21;
      logic [63:0] offset;
      bit          used;
      used = 1'b0;
      off21 = {{43{w[23]}}, w[23:5], w[30:29]};
      if (!window_resolved && w[4:0] == cur_target) begin
         used = 1'b1;
         if (page_held && (w & arar_pkg::OP_ADD_MASK) == arar_pkg::OP_ADD64_IMM
             && w[9:5] == cur_target) begin
            offset = {52'd0, w[21:10]};
            if ((w & arar_pkg::ADD_SHIFT_BIT) != 0)
               offset = offset << 12;
            expect_result(held_page + offset, 1'b1);
            window_resolved = 1'b1;
         end else if ((w & arar_pkg::OP_ADR_MASK) == arar_pkg::OP_ADRP) begin
            held_page = (a & ~arar_pkg::IMM12_MASK) + (off21 << 12);
            page_held = 1'b1;
         end else if ((w & arar_pkg::OP_ADR_MASK) == arar_pkg::OP_ADR) begin
            expect_result(a + off21, 1'b1);
            window_resolved = 1'b1;
         end else begin
            page_held = 1'b0;
         end
      end
      if (last) begin
         if (!window_resolved) begin
            expect_result(64'd0, 1'b0);
            used = 1'b1;
         end
         page_held = 1'b0;
         held_page = '0;
         window_resolved = 1'b0;
      end
      return used;
   endfunction

   // instruction encoders
   function automatic logic [31:0] adrp_word(input logic [4:0] rd, input logic [20:0] off);
      return arar_pkg::OP_ADRP | {1'b0, off[1:0], 5'd0, off[20:2], rd};
   endfunction

   function automatic logic [31:0] adr_word(input logic [4:0] rd, input logic [20:0] off);
      return arar_pkg::OP_ADR | {1'b0, off[1:0], 5'd0, off[20:2], rd};
   endfunction

   function automatic logic [31:0] add_word(input logic [4:0] rd, input logic [4:0] rn,
                                            input logic [11:0] imm, input logic sh,
                                            input logic b23);
      return arar_pkg::OP_ADD64_IMM | {8'd0, b23, sh, imm, rn, rd};
   endfunction

   // send one beat on req, with random idle gaps before it
   task automatic send_word(input logic [31:0] w, input logic [63:0] a, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_insn_word <= w;
      req_insn_addr <= a;
      req_last_word <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (track_word(w, a, last))
         words_used++;
      words_sent++;
   endtask

   // stop sending until every expected beat is back and the pipe is empty
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_resolutions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr write of target_reg followed by a read-back
   task automatic write_target(input logic [4:0] t);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= TARGET_ADDR;
      csr_pwdata  <= {27'd0, t};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_target = t;
      @(posedge clock);
      csr_psel    <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {27'd0, t})
         log_mismatch("target_reg read-back", {32'd0, csr_prdata}, {59'd0, t});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [63:0] pick_addr();
      case ($urandom_range(9))
         0: return 64'($urandom_range(0, 255)) << 2;
         1: return ~(64'($urandom_range(0, 255)) << 2);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly well-formed adrp/add/adr traffic to the target, plus noise
   function automatic logic [31:0] random_insn();
      int          kind;
      logic [31:0] w;
      logic [4:0]  rn;
      kind = $urandom_range(99);
      w = $urandom;
      rn = ($urandom_range(6) == 0) ? 5'($urandom) : cur_target;
      if (kind < 25)
         w = adrp_word(cur_target, 21'($urandom));
      else if (kind < 35)
         w = adr_word(cur_target, 21'($urandom));
      else if (kind < 60)
         w = add_word(cur_target, rn, 12'($urandom), 1'($urandom), 1'($urandom));
      else if (kind < 70)
         w[4:0] = cur_target;
      else if (kind < 88)
         w[4:0] = cur_target ^ 5'($urandom_range(1, 31));
      return w;
   endfunction

   task automatic send_random_window();
      int          n;
      logic [63:0] base;
      logic [63:0] a;
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      base = pick_addr();
      for (int i = 0; i < n; i++) begin
         a = ($urandom_range(7) == 0) ? {$urandom, $urandom} : base + 64'(4 * i);
         send_word(random_insn(), a, i == n - 1);
      end
   endtask

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_resolutions.size() == 0) begin
            log_mismatch("unexpected result beat", rsp_resolved_addr, 64'd0);
         end else begin
            oldest = pending_resolutions.pop_front();
            if (rsp_found !== oldest.found)
               log_mismatch("found", {63'd0, rsp_found}, {63'd0, oldest.found});
            if (rsp_resolved_addr !== oldest.addr)
               log_mismatch("resolved_addr", rsp_resolved_addr, oldest.addr);
            if (oldest.found)
               found_checked++;
            else
               missing_checked++;
         end
      end
   end

   // corner cases with the reset target (x0)
   task automatic test_directed_cases();
      // adr with the largest and the most negative offsets
      send_word(adr_word(5'd0, 21'h0FFFFF), 64'd0, 1'b1);
      send_word(adr_word(5'd0, 21'h100000), 64'h10, 1'b1);
      // adrp+add at the top and bottom of the address space
      send_word(adrp_word(5'd0, 21'h0FFFFF), 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_word(add_word(5'd0, 5'd0, 12'hFFF, 1'b0, 1'b0), 64'h4, 1'b1);
      send_word(adrp_word(5'd0, 21'h100000), 64'd0, 1'b0);
      send_word(add_word(5'd0, 5'd0, 12'hFFF, 1'b1, 1'b1), 64'h4, 1'b1);
      // other write drops the page, so the add cannot resolve
      send_word(adrp_word(5'd0, 21'h1), 64'h4000_1234, 1'b0);
      send_word(32'hD280_0000, 64'h4000_1238, 1'b0);
      send_word(add_word(5'd0, 5'd0, 12'h005, 1'b0, 1'b0), 64'h4000_123C, 1'b1);
      // new adrp replaces page, add from another source drops it, words after hit ignored
      send_word(adrp_word(5'd0, 21'h2), 64'h8000, 1'b0);
      send_word(adrp_word(5'd0, 21'h3), 64'h8004, 1'b0);
      send_word(add_word(5'd0, 5'd7, 12'h010, 1'b0, 1'b0), 64'h8008, 1'b0);
      send_word(adrp_word(5'd0, 21'h4), 64'h800C, 1'b0);
      send_word(add_word(5'd0, 5'd0, 12'h123, 1'b0, 1'b1), 64'h8010, 1'b0);
      send_word(adr_word(5'd0, 21'h5), 64'h8014, 1'b0);
      send_word(32'h0000_0000, 64'h8018, 1'b1);
      // word for another register, then an all-zero word to the target
      send_word(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_word(32'h0000_0000, 64'd0, 1'b1);
      wait_for_results();
   endtask

   // random windows under one idle mix, swept over three targets
   task automatic test_random_traffic(input int s_idle, input int r_idle,
                                      input logic [4:0] t0, input logic [4:0] t1,
                                      input logic [4:0] t2);
      logic [4:0] targets [3];
      int         start;
      targets = '{t0, t1, t2};
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      foreach (targets[k]) begin
         wait_for_results();
         write_target(targets[k]);
         start = words_sent;
         while (words_sent - start < PHASE_WORDS)
            send_random_window();
      end
      wait_for_results();
   endtask

   // long rsp hold-off while single-word adr windows keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++)
         send_word(adr_word(cur_target, 21'($urandom)), {$urandom, $urandom}, 1'b1);
      wait_for_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic(19, 60, 5'd31, 5'd0, 5'($urandom));
      test_random_traffic(60, 19, 5'($urandom), 5'd31, 5'($urandom));
      test_random_traffic(0, 0, 5'd0, 5'($urandom), 5'd31);
      test_backpressure();
      $display("ran %0d words, %0d reaching the target; checked %0d hits, %0d misses",
               words_sent, words_used, found_checked, missing_checked);
      $display("targets 0, 31 and random under three idle mixes, one %0d-cycle rsp hold",
               HOLD_CYCLES);
      if (errors == 0 && pending_resolutions.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/arar_pkg.sv
hw/rtl/arar_csr.sv
hw/rtl/arar_step.sv
hw/rtl/arm64_adrp_add_resolver.sv
tb/testbench.sv
